// ===== rtl/glmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmd_pkg: shared types and constants for the grid local minimum detector
// Field widths, configuration codes, queue sizing and the task word that
// travels from the classifying front to the reporting back end.
// ----------------------------------------------------------------------------
package glmd_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int HGT_W  = 4;
    localparam int POS_W  = 7;
    localparam int RISK_W = 19;
    localparam int CFG_W  = 8;

    localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd100;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd100;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // decided results of one cell, in report order: up, left, final, summary
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [HGT_W-1:0] up_h;
        logic             ok_up;
        logic [HGT_W-1:0] left_h;
        logic             ok_left;
        logic [HGT_W-1:0] cur_h;
        logic             ok_fin;
        logic             is_final;
    } t_task;

endpackage

// ===== rtl/grid_local_minimum_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_minimum_detector: four-neighbour strict minima over a raster map
// Path: a deciding cell passes the stage one registers, the task queue and
// the output register. Throughput: one cell per cycle while o_in_stall is low;
// a cell with k results yields k sequencer words, one per cycle unless stalled.
// Reset: counters, risk total and queue clear, frame size returns to 100x100;
// the line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module grid_local_minimum_detector import glmd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [HGT_W-1:0]  i_cell_height,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_col_index,
    output logic [POS_W-1:0]  o_row_index,
    output logic [HGT_W-1:0]  o_low_height,
    output logic [RISK_W-1:0] o_risk_total,
    output logic              o_frame_done,
    output logic              o_last_of_run,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    logic             push;
    t_task            push_task;
    logic             pop;
    t_task            head;
    logic             head_valid;
    logic [Q_CW-1:0]  q_count;

    assign o_cfg_ready = 1'b1;

    // decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    glmd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_cell_height  (i_cell_height),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_task         (push_task)
    );

    glmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_task       (push_task),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_count      (q_count)
    );

    glmd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_col_index   (o_col_index),
        .o_row_index   (o_row_index),
        .o_low_height  (o_low_height),
        .o_risk_total  (o_risk_total),
        .o_frame_done  (o_frame_done),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/glmd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmd_front: raster counters, line buffers and minimum classification
// Accepts one height per cycle while not stalled, reads the two line buffers
// around the current column and decides which neighbours became minima.
// ----------------------------------------------------------------------------
module glmd_front import glmd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [HGT_W-1:0] i_cell_height,
    input  logic [CFG_W-1:0] i_frame_width,
    input  logic [CFG_W-1:0] i_frame_height,
    input  logic [Q_CW-1:0]  i_q_count,
    output logic             o_push,
    output t_task            o_task
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WXW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HXW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    // line buffers: row above (two copies for read ports) and two rows above
    logic [HGT_W-1:0] r_mem_a0 [MAX_WIDTH];
    logic [HGT_W-1:0] r_mem_a1 [MAX_WIDTH];
    logic [HGT_W-1:0] r_mem_b  [MAX_WIDTH];

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [HGT_W-1:0] r_prev;

    logic [WXW-1:0]   fw_x;
    logic [HXW-1:0]   fh_x;
    logic [CW-1:0]    wlast;
    logic [RW-1:0]    hlast;
    logic [CW-1:0]    col_c;
    logic [RW-1:0]    row_c;
    logic             last_col;
    logic             last_row;
    logic             accept;

    // stage one registers
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_col;
    logic [POS_W-1:0] r_s1_col7;
    logic [POS_W-1:0] r_s1_row7;
    logic             r_s1_r_gt0;
    logic             r_s1_r_gt1;
    logic             r_s1_c_gt0;
    logic             r_s1_c_gt1;
    logic             r_s1_last_col;
    logic             r_s1_last_row;
    logic [HGT_W-1:0] r_s1_cur;
    logic [HGT_W-1:0] r_s1_prev;
    logic             r_fwd_c;
    logic             r_fwd_l;
    logic [HGT_W-1:0] r_fwd_h;
    logic [HGT_W-1:0] r_rd_ac;
    logic [HGT_W-1:0] r_rd_ar;
    logic [HGT_W-1:0] r_rd_al1;
    logic [HGT_W-1:0] r_rd_al2;
    logic [HGT_W-1:0] r_rd_bc;
    logic [HGT_W-1:0] r_rd_bl;

    logic [HGT_W-1:0] up_h;
    logic [HGT_W-1:0] up2_h;
    logic [HGT_W-1:0] bl_h;
    logic             ok_up;
    logic             ok_left;
    logic             ok_fin;
    logic             is_final;

    // hold input while the queue may not take the cell in flight
    assign o_stall = (i_q_count + Q_CW'(r_s1_valid)) >= Q_CW'(Q_DEPTH);
    assign accept  = i_valid && !o_stall;

    // clamp frame size and position
    always_comb begin
        fw_x = WXW'(i_frame_width);
        fh_x = HXW'(i_frame_height);
        if (i_frame_width == '0) begin
            wlast = '0;
        end else if (fw_x > WXW'(MAX_WIDTH)) begin
            wlast = CW'(MAX_WIDTH - 1);
        end else begin
            wlast = CW'(fw_x - WXW'(1));
        end
        if (i_frame_height == '0) begin
            hlast = '0;
        end else if (fh_x > HXW'(MAX_HEIGHT)) begin
            hlast = RW'(MAX_HEIGHT - 1);
        end else begin
            hlast = RW'(fh_x - HXW'(1));
        end
        col_c    = (r_col > wlast) ? wlast : r_col;
        row_c    = (r_row > hlast) ? hlast : r_row;
        last_col = (col_c == wlast);
        last_row = (row_c == hlast);
    end

    // advance raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
        end else if (accept) begin
            r_prev <= i_cell_height;
            if (last_row && last_col) begin
                r_col <= '0;
                r_row <= '0;
            end else if (last_col) begin
                r_col <= '0;
                r_row <= row_c + RW'(1);
            end else begin
                r_col <= col_c + CW'(1);
                r_row <= row_c;
            end
        end
    end

    // row above: write the new cell, read around the column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_ac  <= r_mem_a0[col_c];
            r_rd_ar  <= r_mem_a0[col_c + CW'(1)];
            r_rd_al1 <= r_mem_a1[col_c - CW'(1)];
            r_rd_al2 <= r_mem_a1[col_c - CW'(2)];
            r_mem_a0[col_c] <= i_cell_height;
            r_mem_a1[col_c] <= i_cell_height;
        end
    end

    // two rows above: written from the registered row-above read in the next cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem_b[r_s1_col] <= r_rd_ac;
        end
        if (accept) begin
            r_rd_bc <= r_mem_b[col_c];
            r_rd_bl <= r_mem_b[col_c - CW'(1)];
        end
    end

    // stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    // capture position flags and bypass of the shift write in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= col_c;
            r_s1_col7     <= POS_W'(col_c);
            r_s1_row7     <= POS_W'(row_c);
            r_s1_r_gt0    <= (row_c != '0);
            r_s1_r_gt1    <= (row_c > RW'(1));
            r_s1_c_gt0    <= (col_c != '0);
            r_s1_c_gt1    <= (col_c > CW'(1));
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
            r_s1_cur      <= i_cell_height;
            r_s1_prev     <= r_prev;
            r_fwd_c       <= r_s1_valid && (r_s1_col == col_c);
            r_fwd_l       <= r_s1_valid && (r_s1_col == col_c - CW'(1));
            r_fwd_h       <= r_rd_ac;
        end
    end

    // classify the cell above, the cell to the left and the final cell
    always_comb begin
        up_h  = r_rd_ac;
        up2_h = r_fwd_c ? r_fwd_h : r_rd_bc;
        bl_h  = r_fwd_l ? r_fwd_h : r_rd_bl;

        ok_up = r_s1_r_gt0 && (r_s1_cur > up_h);
        if (r_s1_c_gt0 && (bl_h <= up_h)) ok_up = 1'b0;
        if (!r_s1_last_col && (r_rd_ar <= up_h)) ok_up = 1'b0;
        if (r_s1_r_gt1 && (up2_h <= up_h)) ok_up = 1'b0;

        ok_left = r_s1_last_row && r_s1_c_gt0 && (r_s1_cur > r_s1_prev);
        if (r_s1_c_gt1 && (r_rd_al2 <= r_s1_prev)) ok_left = 1'b0;
        if (r_s1_r_gt0 && (bl_h <= r_s1_prev)) ok_left = 1'b0;

        is_final = r_s1_last_row && r_s1_last_col;
        ok_fin   = is_final;
        if (r_s1_c_gt0 && (r_rd_al1 <= r_s1_cur)) ok_fin = 1'b0;
        if (r_s1_r_gt0 && (up_h <= r_s1_cur)) ok_fin = 1'b0;

        o_task.col      = r_s1_col7;
        o_task.row      = r_s1_row7;
        o_task.up_h     = up_h;
        o_task.ok_up    = ok_up;
        o_task.left_h   = r_s1_prev;
        o_task.ok_left  = ok_left;
        o_task.cur_h    = r_s1_cur;
        o_task.ok_fin   = ok_fin;
        o_task.is_final = is_final;

        // drop cells that decide nothing
        o_push = r_s1_valid && (ok_up || ok_left || is_final);
    end

endmodule

// ===== rtl/glmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmd_queue: short task queue between front and back
// Holds decided cells so that classification and reporting stall apart.
// ----------------------------------------------------------------------------
module glmd_queue import glmd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_task           i_task,
    input  logic            i_pop,
    output t_task           o_head,
    output logic            o_head_valid,
    output logic [Q_CW-1:0] o_count
);

    t_task            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_CW-1:0]  r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_count      = r_count;

    // store pushed task
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/glmd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmd_back: result sequencer, risk accumulator and output register
// Emits each queued cell's results in order, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module glmd_back import glmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_task             i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [POS_W-1:0]  o_col_index,
    output logic [POS_W-1:0]  o_row_index,
    output logic [HGT_W-1:0]  o_low_height,
    output logic [RISK_W-1:0] o_risk_total,
    output logic              o_frame_done,
    output logic              o_last_of_run
);

    logic [3:0]        r_done;
    logic [RISK_W-1:0] r_risk;
    logic              r_valid;
    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic [HGT_W-1:0]  r_hgt;
    logic [RISK_W-1:0] r_risk_out;
    logic              r_frame_done;
    logic              r_last;

    logic [3:0]        pend;
    logic [3:0]        sel;
    logic              load;
    logic              last;
    logic [POS_W-1:0]  sel_col;
    logic [POS_W-1:0]  sel_row;
    logic [HGT_W-1:0]  sel_hgt;
    logic [RISK_W:0]   sum;
    logic [RISK_W-1:0] risk_add;
    logic [RISK_W-1:0] n_risk;
    logic [RISK_W-1:0] n_risk_out;

    // pick the next pending result of the head cell
    always_comb begin
        pend = {i_head.is_final, i_head.ok_fin, i_head.ok_left, i_head.ok_up} & ~r_done;
        load = i_head_valid && (!r_valid || !i_stall);
        if (pend[0])      sel = 4'b0001;
        else if (pend[1]) sel = 4'b0010;
        else if (pend[2]) sel = 4'b0100;
        else              sel = 4'b1000;
        last  = ((pend & ~sel) == 4'b0000);
        o_pop = load && last;

        sel_col = '0;
        sel_row = '0;
        sel_hgt = '0;
        case (sel)
            4'b0001: begin
                sel_col = i_head.col;
                sel_row = i_head.row - POS_W'(1);
                sel_hgt = i_head.up_h;
            end
            4'b0010: begin
                sel_col = i_head.col - POS_W'(1);
                sel_row = i_head.row;
                sel_hgt = i_head.left_h;
            end
            4'b0100: begin
                sel_col = i_head.col;
                sel_row = i_head.row;
                sel_hgt = i_head.cur_h;
            end
            default: begin
                sel_col = '0;
            end
        endcase

        // saturating add of height plus one
        sum      = {1'b0, r_risk} + (RISK_W + 1)'(sel_hgt) + (RISK_W + 1)'(1);
        risk_add = sum[RISK_W] ? RISK_MAX : sum[RISK_W-1:0];
        if (sel[3]) begin
            n_risk_out = r_risk;
            n_risk     = '0;
        end else begin
            n_risk_out = risk_add;
            n_risk     = risk_add;
        end
    end

    // track emitted results and the running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_risk  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_done  <= last ? 4'b0000 : (r_done | sel);
                r_risk  <= n_risk;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // load output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_col        <= sel_col;
            r_row        <= sel_row;
            r_hgt        <= sel_hgt;
            r_risk_out   <= n_risk_out;
            r_frame_done <= sel[3];
            r_last       <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_col_index   = r_col;
    assign o_row_index   = r_row;
    assign o_low_height  = r_hgt;
    assign o_risk_total  = r_risk_out;
    assign o_frame_done  = r_frame_done;
    assign o_last_of_run = r_last;

endmodule

// ===== tb/sv/grid_local_minimum_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_minimum_detector_test: self-checking bench for the minimum finder
// Streams height maps of many sizes through the detector. A built-in model of
// the line buffers and counters predicts every low point and frame summary,
// and the monitor checks each output word against the oldest prediction.
// Both handshakes idle at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module grid_local_minimum_detector_test;
    import glmd_pkg::*;

    localparam int          MAX_W         = DEF_MAX_WIDTH;
    localparam int          MAX_H         = DEF_MAX_HEIGHT;
    localparam int          RESET_DIM     = 100;
    localparam int          IDLE_PCT      = 31;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          RANDOM_CELLS  = 76;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [HGT_W-1:0]  hgt;
        logic [RISK_W-1:0] risk;
        logic              done;
        logic              last;
    } t_low_point;

    typedef enum logic {ROW_HEIGHT, ROW_REG} t_plan_kind;

    typedef struct packed {
        t_plan_kind       kind;
        logic             reg_idx;
        logic [CFG_W-1:0] value;
        logic             typed;
        logic [1:0]       n_typed;
        t_low_point       typed0;
        t_low_point       typed1;
    } t_plan_row;

    localparam t_low_point NO_LOW = '0;

    // stimulus side
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [HGT_W-1:0] in_height = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             calm      = 1'b0;

    // block outputs
    logic              in_stall;
    logic              out_valid;
    logic [POS_W-1:0]  out_col;
    logic [POS_W-1:0]  out_row;
    logic [HGT_W-1:0]  out_hgt;
    logic [RISK_W-1:0] out_risk;
    logic              out_done;
    logic              out_last;
    logic              cfg_ready;

    // predictor state: line buffers, counters, risk and frame size registers
    logic [HGT_W-1:0]  up_line  [MAX_W];
    logic [HGT_W-1:0]  up2_line [MAX_W];
    int unsigned       col_at;
    int unsigned       row_at;
    logic [HGT_W-1:0]  left_cell;
    logic [RISK_W-1:0] risk_acc;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;

    t_low_point  cell_lows[$];
    t_low_point  pending_lows[$];
    t_plan_row   plan_rows[$];
    t_low_point  seen_word;
    t_low_point  want_word;
    int unsigned cells_fed   = 0;
    int unsigned lows_seen   = 0;
    int unsigned frames_seen = 0;
    int unsigned bad_count   = 0;
    int unsigned cycle_count = 0;

    grid_local_minimum_detector u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cell_height (in_height),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_col_index   (out_col),
        .o_row_index   (out_row),
        .o_low_height  (out_hgt),
        .o_risk_total  (out_risk),
        .o_frame_done  (out_done),
        .o_last_of_run (out_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_lows.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stall the result side at random, except during the calm stretch
    always @(posedge clk) begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic t_low_point low_point(int unsigned col, int unsigned row,
                                             int unsigned hgt, int unsigned risk,
                                             logic done, logic last);
        t_low_point lp;
        lp.col  = POS_W'(col);
        lp.row  = POS_W'(row);
        lp.hgt  = HGT_W'(hgt);
        lp.risk = RISK_W'(risk);
        lp.done = done;
        lp.last = last;
        return lp;
    endfunction

    // zero acts as one, oversize acts as the maximum
    function automatic int unsigned frame_span(logic [CFG_W-1:0] raw, int unsigned maxv);
        if (raw == 0) return 1;
        if (32'(raw) > maxv) return maxv;
        return 32'(raw);
    endfunction

    function automatic logic [RISK_W-1:0] add_low(logic [RISK_W-1:0] acc,
                                                  logic [HGT_W-1:0] v);
        int unsigned s;
        s = int'(acc) + int'(v) + 1;
        return (s > int'(RISK_MAX)) ? RISK_MAX : RISK_W'(s);
    endfunction

    // Work out the words one height causes, in report order, into cell_lows.
    task automatic predict_lows(input logic [HGT_W-1:0] cur);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [HGT_W-1:0] above;
        logic [HGT_W-1:0] above2;
        logic [HGT_W-1:0] v;
        bit               last_col;
        bit               last_row;
        bit               ok;
        t_low_point       word;
        w = frame_span(width_reg, MAX_W);
        h = frame_span(height_reg, MAX_H);
        c = (col_at > w - 1) ? w - 1 : col_at;
        r = (row_at > h - 1) ? h - 1 : row_at;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        above  = up_line[c];
        above2 = up2_line[c];
        cell_lows.delete();

        // decide the cell above, now that its down neighbour is here
        if (r > 0) begin
            v  = above;
            ok = (cur > v);
            if (ok && c > 0 && up2_line[c - 1] <= v) ok = 0;
            if (ok && !last_col && up_line[c + 1] <= v) ok = 0;
            if (ok && r > 1 && above2 <= v) ok = 0;
            if (ok) begin
                risk_acc  = add_low(risk_acc, v);
                word      = low_point(c, r - 1, 32'(v), 32'(risk_acc), 1'b0, 1'b0);
                cell_lows = {cell_lows, word};
            end
        end

        // shift the column down the line buffers
        up2_line[c] = above;
        up_line[c]  = cur;

        // in the last row, decide the cell to the left
        if (last_row && c > 0) begin
            v  = left_cell;
            ok = (cur > v);
            if (ok && c > 1 && up_line[c - 2] <= v) ok = 0;
            if (ok && r > 0 && up2_line[c - 1] <= v) ok = 0;
            if (ok) begin
                risk_acc  = add_low(risk_acc, v);
                word      = low_point(c - 1, r, 32'(v), 32'(risk_acc), 1'b0, 1'b0);
                cell_lows = {cell_lows, word};
            end
        end
        left_cell = cur;

        // final cell decides itself, then the summary closes the frame
        if (last_row && last_col) begin
            ok = 1;
            if (c > 0 && up_line[c - 1] <= cur) ok = 0;
            if (ok && r > 0 && above <= cur) ok = 0;
            if (ok) begin
                risk_acc  = add_low(risk_acc, cur);
                word      = low_point(c, r, 32'(cur), 32'(risk_acc), 1'b0, 1'b0);
                cell_lows = {cell_lows, word};
            end
            word      = low_point(0, 0, 0, 32'(risk_acc), 1'b1, 1'b0);
            cell_lows = {cell_lows, word};
            col_at    = 0;
            row_at    = 0;
            risk_acc  = '0;
        end else if (last_col) begin
            col_at = 0;
            row_at = r + 1;
        end else begin
            col_at = c + 1;
            row_at = r;
        end

        // flag the last word of the run
        if (cell_lows.size() > 0) begin
            cell_lows[cell_lows.size() - 1].last = 1'b1;
        end
    endtask

    // Offer one height, wait for it to be taken, then queue its words.
    task automatic feed_height(input logic [HGT_W-1:0] hgt, input logic typed,
                               input logic [1:0] n_typed, input t_low_point t0,
                               input t_low_point t1);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_height <= hgt;
        do @(posedge clk); while (in_stall);
        cells_fed++;
        predict_lows(hgt);
        if (!typed) begin
            pending_lows = {pending_lows, cell_lows};
        end else begin
            if (n_typed > 0) pending_lows = {pending_lows, t0};
            if (n_typed > 1) pending_lows = {pending_lows, t1};
        end
    endtask

    // Hold the input low until every expected word is back, then settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_lows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_reg(input logic idx, input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
    endtask

    task automatic plan_reg(input logic idx, input logic [CFG_W-1:0] value);
        t_plan_row row;
        row       = '{ROW_REG, idx, value, 1'b0, 2'd0, NO_LOW, NO_LOW};
        plan_rows = {plan_rows, row};
    endtask

    task automatic plan_cell(input logic [HGT_W-1:0] hgt);
        t_plan_row row;
        row       = '{ROW_HEIGHT, CFG_FRAME_WIDTH, CFG_W'(hgt), 1'b0, 2'd0,
                      NO_LOW, NO_LOW};
        plan_rows = {plan_rows, row};
    endtask

    task automatic plan_typed(input logic [HGT_W-1:0] hgt, input logic [1:0] n,
                              input t_low_point t0, input t_low_point t1);
        t_plan_row row;
        row       = '{ROW_HEIGHT, CFG_FRAME_WIDTH, CFG_W'(hgt), 1'b1, n, t0, t1};
        plan_rows = {plan_rows, row};
    endtask

    task automatic note_bad(input string what, input t_low_point want,
                            input t_low_point got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%s at cycle %0d: expected col %0d row %0d h %0d risk %0d done %b last %b",
                     what, cycle_count, want.col, want.row, want.hgt, want.risk,
                     want.done, want.last);
            $display("    got col %0d row %0d h %0d risk %0d done %b last %b",
                     got.col, got.row, got.hgt, got.risk, got.done, got.last);
        end
    endtask

    // check every accepted result word against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen_word = {out_col, out_row, out_hgt, out_risk, out_done, out_last};
            if (pending_lows.size() == 0) begin
                note_bad("word with nothing expected", NO_LOW, seen_word);
            end else begin
                want_word = pending_lows.pop_front();
                if (seen_word !== want_word) note_bad("word mismatch", want_word, seen_word);
                if (want_word.done) frames_seen++;
                else lows_seen++;
            end
        end
    end

    initial begin
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned lo;
        int unsigned span;
        int unsigned cells;
        int unsigned first;
        int unsigned spins;

        // predictor reset
        foreach (up_line[k]) begin
            up_line[k]  = '0;
            up2_line[k] = '0;
        end
        col_at     = 0;
        row_at     = 0;
        left_cell  = '0;
        risk_acc   = '0;
        width_reg  = CFG_W'(RESET_DIM);
        height_reg = CFG_W'(RESET_DIM);

        // Directed table. The first two heights run at the reset size, then
        // the frame shrinks under a counter already past the new last column.
        plan_typed(4'd5, 2'd0, NO_LOW, NO_LOW);
        plan_typed(4'd9, 2'd0, NO_LOW, NO_LOW);
        plan_reg(CFG_FRAME_WIDTH, 8'd2);
        plan_reg(CFG_FRAME_HEIGHT, 8'd1);
        plan_typed(4'd3, 2'd2, low_point(1, 0, 3, 4, 1'b0, 1'b0),
                   low_point(0, 0, 0, 4, 1'b1, 1'b1));
        // zero sizes act as a single cell, top and bottom height
        plan_reg(CFG_FRAME_WIDTH, 8'd0);
        plan_reg(CFG_FRAME_HEIGHT, 8'd0);
        plan_typed(4'd15, 2'd2, low_point(0, 0, 15, 16, 1'b0, 1'b0),
                   low_point(0, 0, 0, 16, 1'b1, 1'b1));
        plan_typed(4'd0, 2'd2, low_point(0, 0, 0, 1, 1'b0, 1'b0),
                   low_point(0, 0, 0, 1, 1'b1, 1'b1));
        // 3x3 checkerboard: corners and center are minima
        plan_reg(CFG_FRAME_WIDTH, 8'd3);
        plan_reg(CFG_FRAME_HEIGHT, 8'd3);
        plan_cell(4'd0);  plan_cell(4'd15); plan_cell(4'd0);
        plan_cell(4'd15); plan_cell(4'd0);  plan_cell(4'd15);
        plan_cell(4'd0);  plan_cell(4'd15); plan_cell(4'd0);
        // flat 2x2: equal neighbours, no strict minimum
        plan_reg(CFG_FRAME_WIDTH, 8'd2);
        plan_reg(CFG_FRAME_HEIGHT, 8'd2);
        plan_cell(4'd7); plan_cell(4'd7); plan_cell(4'd7);
        plan_typed(4'd7, 2'd1, low_point(0, 0, 0, 0, 1'b1, 1'b1), NO_LOW);

        // hold reset, then release
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].kind == ROW_REG) begin
                set_frame_reg(plan_rows[i].reg_idx, plan_rows[i].value);
            end else begin
                feed_height(plan_rows[i].value[HGT_W-1:0], plan_rows[i].typed,
                            plan_rows[i].n_typed, plan_rows[i].typed0,
                            plan_rows[i].typed1);
            end
        end

        // full-width row and full-height column at full rate, oversize values
        calm = 1'b1;
        set_frame_reg(CFG_FRAME_WIDTH, 8'd255);
        set_frame_reg(CFG_FRAME_HEIGHT, 8'd1);
        repeat (MAX_W) feed_height(HGT_W'($urandom_range(15)), 1'b0, 2'd0, NO_LOW, NO_LOW);
        set_frame_reg(CFG_FRAME_WIDTH, 8'd1);
        set_frame_reg(CFG_FRAME_HEIGHT, 8'd240);
        repeat (MAX_H) feed_height(HGT_W'($urandom_range(15)), 1'b0, 2'd0, NO_LOW, NO_LOW);
        calm = 1'b0;

        // random frames, mostly small; some reuse the size back to back
        first = cells_fed;
        while (cells_fed - first < RANDOM_CELLS) begin
            if (cells_fed == first || $urandom_range(9) < 7) begin
                case ($urandom_range(9))
                    0: begin
                        w_raw = 0;
                        h_raw = $urandom_range(6, 1);
                    end
                    1: begin
                        w_raw = $urandom_range(9, 1);
                        h_raw = 0;
                    end
                    default: begin
                        w_raw = $urandom_range(9, 1);
                        h_raw = $urandom_range(6, 1);
                    end
                endcase
                set_frame_reg(CFG_FRAME_WIDTH, CFG_W'(w_raw));
                set_frame_reg(CFG_FRAME_HEIGHT, CFG_W'(h_raw));
            end
            // full range, or a narrow band that makes ties common
            if ($urandom_range(1)) begin
                lo   = 0;
                span = 15;
            end else begin
                lo   = $urandom_range(13);
                span = 2;
            end
            cells = frame_span(width_reg, MAX_W) * frame_span(height_reg, MAX_H);
            repeat (cells) begin
                feed_height(HGT_W'($urandom_range(lo + span, lo)), 1'b0, 2'd0,
                            NO_LOW, NO_LOW);
            end
        end

        // drain, then count anything still outstanding as a failure
        in_valid <= 1'b0;
        spins = 0;
        while (pending_lows.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_lows.size() != 0) begin
            $display("%0d expected words never arrived", pending_lows.size());
            bad_count += pending_lows.size();
        end

        $display("fed %0d heights; checked %0d low points and %0d frame summaries",
                 cells_fed, lows_seen, frames_seen);
        $display("frames ran from 1x1 to 128 wide and 128 tall, zero and oversize sizes too");
        if (bad_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures", bad_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
